// ----- src/sbc_pkg.sv -----
// Shared types, constants and small helper functions for the seconds-to-BCD calendar.
package sbc_pkg;

    // Fixed calendar constants
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN   = 32'd60;
    localparam logic [31:0] DAYS_IN_RANGE  = 32'd36525;
    localparam logic [31:0] DAYS_PER_QUAD  = 32'd1461;
    localparam logic [31:0] DAYS_LEAP_YEAR = 32'd366;
    localparam logic [31:0] DAYS_PLAIN_YR  = 32'd365;
    localparam logic [3:0]  LAST_MONTH     = 4'd12;

    // Request payload
    typedef struct packed {
        logic [31:0] seconds;
    } t_in_item;

    // Result payload
    typedef struct packed {
        logic [7:0] year_bcd;
        logic [4:0] month_bcd;
        logic [5:0] day_bcd;
        logic [5:0] hour_bcd;
        logic [6:0] minute_bcd;
        logic [6:0] second_bcd;
        logic       out_of_range;
    } t_out_item;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_DAY   = 10'b00_0000_0010,
        ST_CHK   = 10'b00_0000_0100,
        ST_QUAD  = 10'b00_0000_1000,
        ST_YEAR  = 10'b00_0001_0000,
        ST_MONTH = 10'b00_0010_0000,
        ST_HOUR  = 10'b00_0100_0000,
        ST_MIN   = 10'b00_1000_0000,
        ST_PACK  = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } t_state;

    // Days in month m (1..12), with the leap day for February
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    // Two BCD digits of a value below 100
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] t10;
        logic [6:0] ones;
        tens = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (v >= 7'(i * 10)) begin
                tens = 4'(i);
            end
        end
        t10  = 7'(tens) * 7'd10;
        ones = v - t10;
        return {tens, ones[3:0]};
    endfunction

endpackage

// ----- src/sbc_stream_if.sv -----
// Valid/ready stream channel carrying one payload per request.
interface sbc_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/seconds_to_bcd_calendar.sv -----
// Top level: converts a seconds count into BCD date and time with one shared subtractor.
//
//  Channel | Dir | Payload                                           | Handshake
//  i_in    | in  | seconds[31:0]                                     | valid/ready
//  o_out   | out | year, month, day, hour, minute, second (BCD), oor | valid/ready
//
// A request runs through 16 restoring steps for the day split, one range
// check, then up to 25 four-year and 4 single-year passes (each loop ends
// on a failed compare), up to 12 month passes and 5 hour and 6 minute steps,
// all through the one subtractor, then a packing step. Counts beyond year 99
// end after the range check with only the out-of-range flag set. Reset is
// synchronous and returns the sequencer to idle. The input is ready only in
// idle; a result holds on o_out until taken, and a new request is accepted
// the cycle after.
module seconds_to_bcd_calendar (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sbc_stream_if.sink   i_in,
    sbc_stream_if.source o_out
);
    import sbc_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_days, n_days;
    logic [3:0]  r_bit, n_bit;
    logic [6:0]  r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    t_out_item   r_out, n_out;

    logic [31:0] w_sub_a, w_sub_b, w_diff;
    logic        w_ge;
    logic [4:0]  w_day_p1;

    sbc_sub_unit u_sub (
        .i_a    (w_sub_a),
        .i_b    (w_sub_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_DONE);
    assign o_out.data  = r_out;
    assign w_day_p1    = r_days[4:0] + 5'd1;

    // Sequence the shared subtractor through each field
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_days  = r_days;
        n_bit   = r_bit;
        n_year  = r_year;
        n_month = r_month;
        n_hour  = r_hour;
        n_min   = r_min;
        n_out   = r_out;
        w_sub_a = r_acc;
        w_sub_b = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_acc   = i_in.data.seconds;
                    n_days  = '0;
                    n_bit   = 4'd15;
                    n_state = ST_DAY;
                end
            end
            ST_DAY: begin
                // Restoring division by the day length, one quotient bit a cycle
                w_sub_b = SECS_PER_DAY << r_bit;
                if (w_ge) begin
                    n_acc         = w_diff;
                    n_days[r_bit] = 1'b1;
                end
                if (r_bit == 4'd0) begin
                    n_state = ST_CHK;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            ST_CHK: begin
                w_sub_a = 32'(r_days);
                w_sub_b = DAYS_IN_RANGE;
                if (w_ge) begin
                    n_out              = '0;
                    n_out.out_of_range = 1'b1;
                    n_state            = ST_DONE;
                end else begin
                    n_year  = '0;
                    n_state = ST_QUAD;
                end
            end
            ST_QUAD: begin
                // Strip whole four-year blocks, each starting with a leap year
                w_sub_a = 32'(r_days);
                w_sub_b = DAYS_PER_QUAD;
                if (w_ge) begin
                    n_days = w_diff[15:0];
                    n_year = r_year + 7'd4;
                end else begin
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR: begin
                w_sub_a = 32'(r_days);
                w_sub_b = (r_year[1:0] == 2'b00) ? DAYS_LEAP_YEAR : DAYS_PLAIN_YR;
                if (w_ge) begin
                    n_days = w_diff[15:0];
                    n_year = r_year + 7'd1;
                end else begin
                    n_month = 4'd1;
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                w_sub_a = 32'(r_days);
                w_sub_b = 32'(month_days(r_month, r_year[1:0] == 2'b00));
                if (r_month == LAST_MONTH || !w_ge) begin
                    n_hour  = '0;
                    n_bit   = 4'd4;
                    n_state = ST_HOUR;
                end else begin
                    n_days  = w_diff[15:0];
                    n_month = r_month + 4'd1;
                end
            end
            ST_HOUR: begin
                // Hours from the seconds of the day, one bit a cycle
                w_sub_b = SECS_PER_HOUR << r_bit;
                if (w_ge) begin
                    n_acc              = w_diff;
                    n_hour[r_bit[2:0]] = 1'b1;
                end
                if (r_bit == 4'd0) begin
                    n_min   = '0;
                    n_bit   = 4'd5;
                    n_state = ST_MIN;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            ST_MIN: begin
                w_sub_b = SECS_PER_MIN << r_bit;
                if (w_ge) begin
                    n_acc             = w_diff;
                    n_min[r_bit[2:0]] = 1'b1;
                end
                if (r_bit == 4'd0) begin
                    n_state = ST_PACK;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            ST_PACK: begin
                // Convert every field to BCD and hold the result
                n_out.year_bcd     = to_bcd(r_year);
                n_out.month_bcd    = 5'(to_bcd(7'(r_month)));
                n_out.day_bcd      = 6'(to_bcd(7'(w_day_p1)));
                n_out.hour_bcd     = 6'(to_bcd(7'(r_hour)));
                n_out.minute_bcd   = 7'(to_bcd(7'(r_min)));
                n_out.second_bcd   = 7'(to_bcd(7'(r_acc[5:0])));
                n_out.out_of_range = 1'b0;
                n_state            = ST_DONE;
            end
            ST_DONE: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_days  <= n_days;
        r_bit   <= n_bit;
        r_year  <= n_year;
        r_month <= n_month;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_out   <= n_out;
    end

endmodule

// ----- src/sbc_sub_unit.sv -----
// Compare-and-subtract unit shared by all the dividing, checking and counting steps of the sequencer.
module sbc_sub_unit (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_diff,
    output logic        o_ge
);

    logic [32:0] w_diff;

    // Subtract with a borrow bit; no borrow means a >= b
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_diff[31:0];
    assign o_ge   = ~w_diff[32];

endmodule
